>>> design/yppc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Yaw PID controller package
// Widths, limits, register indexes and direction codes shared by the design.
// ----------------------------------------------------------------------------
package yppc_pkg;

    localparam int ANGLE_W  = 16;               // Q10.6 angle
    localparam int ERR_W    = ANGLE_W + 1;      // difference of two angles
    localparam int SUM_W    = 32;               // saturating integral
    localparam int GAIN_W   = 16;               // Q8.8 gains
    localparam int ACC_W    = 50;               // sum of the three products
    localparam int CNT_W    = $clog2(GAIN_W);
    localparam int PWM_W    = 8;
    localparam int BAND_W   = 15;
    localparam int DIR_W    = 2;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 3;

    // Clamp limit of the PID sum: 120 degrees in Q.14.
    localparam int OUT_LIMIT_DEG = 120;
    localparam int LIMIT_FRAC    = 14;
    localparam logic [ACC_W-1:0] ACC_LIMIT =
        ACC_W'(OUT_LIMIT_DEG * (2 ** LIMIT_FRAC));
    localparam int MAG_W = $clog2(OUT_LIMIT_DEG * (2 ** LIMIT_FRAC) + 1);

    // pwm = |clamped| * 17 / 2^17, which is |clamped| * 2.125 / 2^14.
    localparam int SCALE_SHIFT = 17;
    localparam int SCALE_W     = MAG_W + 5;

    localparam logic [PWM_W-1:0] FULL_PWM    = 8'd255;
    localparam logic [PWM_W-1:0] MIN_PWM_RST = 8'd120;
    localparam logic [GAIN_W-1:0] KP_RST     = 16'd256;
    localparam logic [BAND_W-1:0] BAND_RST   = 15'd320;

    typedef enum logic [DIR_W-1:0] {
        DIR_ACW = 2'd0,
        DIR_CW  = 2'd1,
        DIR_FWD = 2'd2
    } t_dir;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET  = 3'd0,
        CFG_KP      = 3'd1,
        CFG_KI_DT   = 3'd2,
        CFG_KD_DT   = 3'd3,
        CFG_MIN_PWM = 3'd4,
        CFG_BAND    = 3'd5
    } t_cfg_idx;

endpackage

>>> design/yppc_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Yaw sample channel
// Valid/ready channel carrying one yaw sample per word.
// ----------------------------------------------------------------------------
interface yppc_in_if import yppc_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic signed [ANGLE_W-1:0] yaw_sample;

    modport source (output valid, output yaw_sample, input ready);
    modport sink   (input valid, input yaw_sample, output ready);
endinterface

>>> design/yppc_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thruster command channel
// Valid/ready channel carrying pwm level, direction and status per word.
// ----------------------------------------------------------------------------
interface yppc_out_if import yppc_pkg::*;;
    logic             valid;
    logic             ready;
    logic [PWM_W-1:0] pwm_level;
    logic [DIR_W-1:0] direction;
    logic             reached;
    logic             last;

    modport source (output valid, output pwm_level, output direction,
                    output reached, output last, input ready);
    modport sink   (input valid, input pwm_level, input direction,
                    input reached, input last, output ready);
endinterface

>>> design/yppc_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit-serial PID multiply-accumulate
// Forms kp*err + ki*sum + kd*delta, one gain bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module yppc_mac import yppc_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [GAIN_W-1:0]        i_kp,
    input  logic [GAIN_W-1:0]        i_ki,
    input  logic [GAIN_W-1:0]        i_kd,
    input  logic signed [ERR_W-1:0]  i_err,
    input  logic signed [SUM_W-1:0]  i_sum,
    input  logic signed [ERR_W-1:0]  i_delta,
    output logic                     o_done,
    output logic [ACC_W-1:0]         o_acc
);

    logic [GAIN_W-1:0] r_kp, r_ki, r_kd;
    logic [ERR_W-1:0]  r_err, r_delta;
    logic [SUM_W-1:0]  r_sum;
    logic [ACC_W-1:0]  r_acc;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [ACC_W-1:0] err_x, sum_x, delta_x;
    logic [ACC_W-1:0] n_acc;

    always_comb begin
        err_x   = r_kp[GAIN_W-1] ? {{(ACC_W-ERR_W){r_err[ERR_W-1]}}, r_err} : '0;
        sum_x   = r_ki[GAIN_W-1] ? {{(ACC_W-SUM_W){r_sum[SUM_W-1]}}, r_sum} : '0;
        delta_x = r_kd[GAIN_W-1] ?
                  {{(ACC_W-ERR_W){r_delta[ERR_W-1]}}, r_delta} : '0;
        n_acc   = {r_acc[ACC_W-2:0], 1'b0} + err_x + sum_x + delta_x;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_kp    <= i_kp;
                r_ki    <= i_ki;
                r_kd    <= i_kd;
                r_err   <= i_err;
                r_sum   <= i_sum;
                r_delta <= i_delta;
                r_acc   <= '0;
                r_cnt   <= '0;
                r_busy  <= 1'b1;
            end else if (r_busy) begin
                r_acc <= n_acc;
                r_kp  <= {r_kp[GAIN_W-2:0], 1'b0};
                r_ki  <= {r_ki[GAIN_W-2:0], 1'b0};
                r_kd  <= {r_kd[GAIN_W-2:0], 1'b0};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(GAIN_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_acc  = r_acc;

endmodule

>>> design/yppc_shape.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID output shaper
// Clamps the PID sum, scales its magnitude to pwm and applies the floor.
// ----------------------------------------------------------------------------
module yppc_shape import yppc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [ACC_W-1:0]  i_acc,
    input  logic [PWM_W-1:0]  i_min_pwm,
    output logic              o_done,
    output logic              o_neg,
    output logic [PWM_W-1:0]  o_pwm
);

    logic [MAG_W-1:0]   r_mag;
    logic               r_neg;
    logic               r_done;

    logic [ACC_W-1:0]   neg_acc;
    logic [MAG_W-1:0]   n_mag;
    logic [SCALE_W-1:0] scaled;
    logic [PWM_W-1:0]   mag_pwm;

    always_comb begin
        neg_acc = -i_acc;
        if ($signed(i_acc) > $signed(ACC_LIMIT)) begin
            n_mag = ACC_LIMIT[MAG_W-1:0];
        end else if ($signed(i_acc) < -$signed(ACC_LIMIT)) begin
            n_mag = ACC_LIMIT[MAG_W-1:0];
        end else if (i_acc[ACC_W-1]) begin
            n_mag = neg_acc[MAG_W-1:0];
        end else begin
            n_mag = i_acc[MAG_W-1:0];
        end
    end

    // Multiply by 17 as a shift and add; the clamp keeps the result within 255.
    assign scaled  = {r_mag, 4'b0000} + SCALE_W'(r_mag);
    assign mag_pwm = scaled[SCALE_SHIFT +: PWM_W];
    assign o_pwm   = (mag_pwm < i_min_pwm) ? i_min_pwm : mag_pwm;
    assign o_neg   = r_neg;
    assign o_done  = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_start;
            if (i_start) begin
                r_mag <= n_mag;
                r_neg <= i_acc[ACC_W-1];
            end
        end
    end

endmodule

>>> design/yaw_pid_pwm_controller_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Yaw PID to thruster pwm controller
// PID heading loop on yaw samples, mapped to a pwm level and turn direction.
// ----------------------------------------------------------------------------
//
//  Channel   | Dir | Handshake     | Word contents
//  ----------+-----+---------------+---------------------------------------
//  i_in      | in  | valid/ready   | yaw_sample (signed Q10.6 degrees)
//  o_out     | out | valid/ready   | pwm_level, direction, reached, last
//  i_cfg_*   | in  | write enable  | register index and write data
//
// For a turning sample the accepting edge captures error and delta. Then
// S_SUM updates the saturating integral, S_MAC runs the bit-serial
// multiply-accumulate (one gain bit per cycle), the shaper clamps and
// scales, S_SHAPE hands the result to the sequencer, and S_RES1 loads the
// output register once it is free. Once the heading is reached each sample
// passes through S_FWD and yields one forward word.
// Reset is synchronous and active low; it restores register defaults and
// clears the integral, the stored sample and the reached flag.
// A stalled output holds the word in the output register; the next sample is
// taken while that word waits, and the sequencer stalls only when it needs
// the output register again.
//
module yaw_pid_pwm_controller_top import yppc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    yppc_in_if.sink              i_in,
    yppc_out_if.source           o_out
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_MAC,
        S_SHAPE,
        S_RES1,
        S_FWD
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic [ANGLE_W-1:0] r_target;
    logic [GAIN_W-1:0]  r_kp;
    logic [GAIN_W-1:0]  r_ki_dt;
    logic [GAIN_W-1:0]  r_kd_dt;
    logic [PWM_W-1:0]   r_min_pwm;
    logic [BAND_W-1:0]  r_band;

    // Controller state.
    logic               r_started;
    logic [ANGLE_W-1:0] r_prior;
    logic [SUM_W-1:0]   r_error_sum;
    logic               r_reached;

    // Per-sample working values.
    logic [ERR_W-1:0]   r_err;
    logic [ERR_W-1:0]   r_delta;
    logic               r_hit;

    // Output register.
    logic               r_out_valid;
    logic [PWM_W-1:0]   r_out_pwm;
    t_dir               r_out_dir;
    logic               r_out_reached;
    logic               r_out_last;

    logic               accept;
    logic               out_free;
    logic               out_load;
    logic [ANGLE_W-1:0] prev;
    logic [ERR_W-1:0]   err_in;
    logic [ERR_W-1:0]   delta_in;
    logic [ERR_W-1:0]   abs_err;
    logic               hit_in;
    logic [SUM_W:0]     sum_wide;
    logic [SUM_W-1:0]   sum_sat;

    logic               mac_done;
    logic [ACC_W-1:0]   mac_acc;
    logic               shape_done;
    logic               shape_neg;
    logic [PWM_W-1:0]   shape_pwm;

    assign i_in.ready = (r_state == S_IDLE);
    assign accept     = i_in.valid && i_in.ready;
    assign out_free   = !r_out_valid || o_out.ready;
    // A new word enters the output register this cycle.
    assign out_load   = out_free && ((r_state == S_RES1) || (r_state == S_FWD));

    // Error, delta and band test straight from the incoming sample. The
    // first sample stands in for its own predecessor, so delta starts at 0.
    always_comb begin
        prev     = r_started ? r_prior : i_in.yaw_sample;
        err_in   = {r_target[ANGLE_W-1], r_target}
                 - {i_in.yaw_sample[ANGLE_W-1], i_in.yaw_sample};
        delta_in = {i_in.yaw_sample[ANGLE_W-1], i_in.yaw_sample}
                 - {prev[ANGLE_W-1], prev};
        abs_err  = err_in[ERR_W-1] ? -err_in : err_in;
        hit_in   = abs_err < {2'b00, r_band};
    end

    // Integral update, saturating at the signed 32-bit limits.
    always_comb begin
        sum_wide = {r_error_sum[SUM_W-1], r_error_sum}
                 + {{(SUM_W+1-ERR_W){r_err[ERR_W-1]}}, r_err};
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
            sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                      : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            sum_sat = sum_wide[SUM_W-1:0];
        end
    end

    yppc_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_SUM),
        .i_kp    (r_kp),
        .i_ki    (r_ki_dt),
        .i_kd    (r_kd_dt),
        .i_err   (r_err),
        .i_sum   (sum_sat),
        .i_delta (r_delta),
        .o_done  (mac_done),
        .o_acc   (mac_acc)
    );

    yppc_shape u_shape (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mac_done),
        .i_acc     (mac_acc),
        .i_min_pwm (r_min_pwm),
        .o_done    (shape_done),
        .o_neg     (shape_neg),
        .o_pwm     (shape_pwm)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_target    <= '0;
            r_kp        <= KP_RST;
            r_ki_dt     <= '0;
            r_kd_dt     <= '0;
            r_min_pwm   <= MIN_PWM_RST;
            r_band      <= BAND_RST;
            r_started   <= 1'b0;
            r_prior     <= '0;
            r_error_sum <= '0;
            r_reached   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TARGET:  r_target  <= i_cfg_data[ANGLE_W-1:0];
                    CFG_KP:      r_kp      <= i_cfg_data[GAIN_W-1:0];
                    CFG_KI_DT:   r_ki_dt   <= i_cfg_data[GAIN_W-1:0];
                    CFG_KD_DT:   r_kd_dt   <= i_cfg_data[GAIN_W-1:0];
                    CFG_MIN_PWM: r_min_pwm <= i_cfg_data[PWM_W-1:0];
                    CFG_BAND:    r_band    <= i_cfg_data[BAND_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (r_out_valid && o_out.ready && !out_load) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        // After the heading is reached the state is frozen and
                        // every sample just commands full forward thrust.
                        if (r_reached) begin
                            r_state <= S_FWD;
                        end else begin
                            r_started <= 1'b1;
                            r_prior   <= i_in.yaw_sample;
                            r_err     <= err_in;
                            r_delta   <= delta_in;
                            r_hit     <= hit_in;
                            r_state   <= S_SUM;
                        end
                    end
                end
                S_SUM: begin
                    r_error_sum <= sum_sat;
                    r_state     <= S_MAC;
                end
                S_MAC: begin
                    if (mac_done) begin
                        r_state <= S_SHAPE;
                    end
                end
                S_SHAPE: begin
                    if (shape_done) begin
                        r_state <= S_RES1;
                    end
                end
                S_RES1: begin
                    if (out_free) begin
                        r_out_valid   <= 1'b1;
                        r_out_pwm     <= shape_pwm;
                        r_out_dir     <= shape_neg ? DIR_ACW : DIR_CW;
                        r_out_reached <= 1'b0;
                        r_out_last    <= !r_hit;
                        if (r_hit) begin
                            r_reached <= 1'b1;
                            r_state   <= S_FWD;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_FWD: begin
                    if (out_free) begin
                        r_out_valid   <= 1'b1;
                        r_out_pwm     <= FULL_PWM;
                        r_out_dir     <= DIR_FWD;
                        r_out_reached <= 1'b1;
                        r_out_last    <= 1'b1;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.pwm_level = r_out_pwm;
    assign o_out.direction = r_out_dir;
    assign o_out.reached   = r_out_reached;
    assign o_out.last      = r_out_last;

endmodule

>>> tb/yaw_pid_pwm_controller_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Yaw PID controller testbench
// Streams yaw sample words into the controller under random handshake gaps
// and checks every thruster command word against a behavioral heading loop.
// ----------------------------------------------------------------------------
module yaw_pid_pwm_controller_top_tb;
    import yppc_pkg::*;

    localparam int CLK_HALF_NS  = 6;
    localparam int RESET_CYCLES = 6;
    localparam int RUN_LIMIT_NS = 60_000_000;
    localparam int SETTLE_CYCLES = 30;
    localparam int REPORT_CAP   = 50;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_WORDS  = 145;
    localparam int PUSH_WORDS   = 40;

    // Register indexes outside the map; the block must ignore writes to them.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam logic signed [ANGLE_W-1:0] YAW_MAX = 16'sh7FFF;
    localparam logic signed [ANGLE_W-1:0] YAW_MIN = 16'sh8000;
    localparam longint SUM_MAX   = 64'sd2147483647;
    localparam longint SUM_MIN   = -64'sd2147483648;
    localparam longint SCALE_MUL = 17;

    typedef struct packed {
        logic [PWM_W-1:0] pwm_level;
        t_dir             direction;
        logic             reached;
        logic             last;
    } t_thrust_cmd;

    // Raw register data as written; the upper bits of the narrow registers
    // carry junk so that masking is exercised.
    typedef struct packed {
        logic [CFG_W-1:0] target;
        logic [CFG_W-1:0] kp;
        logic [CFG_W-1:0] ki_dt;
        logic [CFG_W-1:0] kd_over_dt;
        logic [CFG_W-1:0] min_word;
        logic [CFG_W-1:0] band_word;
    } t_heading_cfg;

    // ------------------------------------------------------------------------
    // Heading loop model and command checker. It keeps its own copy of the
    // registers and of the controller state, predicts the command words of
    // each accepted sample, and compares returned words in order.
    // ------------------------------------------------------------------------
    class thrust_scoreboard;
        logic signed [ANGLE_W-1:0] target;
        logic [GAIN_W-1:0]         kp;
        logic [GAIN_W-1:0]         ki_dt;
        logic [GAIN_W-1:0]         kd_over_dt;
        logic [PWM_W-1:0]          min_pwm;
        logic [BAND_W-1:0]         band;
        bit                        started;
        bit                        reached;
        logic signed [ANGLE_W-1:0] prior_yaw;
        longint                    integral;
        t_thrust_cmd               expected_cmds[$];
        int                        mismatches;

        function new();
            target     = '0;
            kp         = KP_RST;
            ki_dt      = '0;
            kd_over_dt = '0;
            min_pwm    = MIN_PWM_RST;
            band       = BAND_RST;
            started    = 1'b0;
            reached    = 1'b0;
            prior_yaw  = '0;
            integral   = 0;
            mismatches = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_TARGET:  target     = data;
                CFG_KP:      kp         = data;
                CFG_KI_DT:   ki_dt      = data;
                CFG_KD_DT:   kd_over_dt = data;
                CFG_MIN_PWM: min_pwm    = data[PWM_W-1:0];
                CFG_BAND:    band       = data[BAND_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_sample(logic signed [ANGLE_W-1:0] yaw);
            longint      err, delta, acc, mag, lim, gp, gi, gd, band_l;
            t_thrust_cmd cmd;
            bit          hit;
            if (reached) begin
                cmd = '{pwm_level: FULL_PWM, direction: DIR_FWD, reached: 1'b1, last: 1'b1};
                expected_cmds.push_back(cmd);
                return;
            end
            // The very first sample doubles as its own predecessor.
            if (!started) begin
                started   = 1'b1;
                prior_yaw = yaw;
            end
            err       = longint'(target) - longint'(yaw);
            delta     = longint'(yaw) - longint'(prior_yaw);
            prior_yaw = yaw;

            integral = integral + err;
            if (integral > SUM_MAX) integral = SUM_MAX;
            if (integral < SUM_MIN) integral = SUM_MIN;

            gp  = kp;
            gi  = ki_dt;
            gd  = kd_over_dt;
            acc = gp * err + gi * integral + gd * delta;
            lim = longint'(OUT_LIMIT_DEG) << LIMIT_FRAC;
            if (acc > lim) acc = lim;
            if (acc < -lim) acc = -lim;

            // Zero counts as clockwise.
            cmd.direction = (acc < 0) ? DIR_ACW : DIR_CW;
            mag = (acc < 0) ? -acc : acc;
            mag = (mag * SCALE_MUL) >> SCALE_SHIFT;
            if (mag > FULL_PWM) mag = FULL_PWM;
            cmd.pwm_level = (mag < min_pwm) ? min_pwm : mag[PWM_W-1:0];

            band_l      = band;
            hit         = ((err < 0) ? -err : err) < band_l;
            cmd.reached = 1'b0;
            cmd.last    = !hit;
            expected_cmds.push_back(cmd);
            if (hit) begin
                reached = 1'b1;
                cmd = '{pwm_level: FULL_PWM, direction: DIR_FWD, reached: 1'b1, last: 1'b1};
                expected_cmds.push_back(cmd);
            end
        endfunction

        function void compare_field(string field, logic [PWM_W-1:0] want,
                                    logic [PWM_W-1:0] got);
            if (got !== want) begin
                mismatches++;
                if (mismatches <= REPORT_CAP)
                    $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
            end
        endfunction

        function void check_command(logic [PWM_W-1:0] pwm, logic [DIR_W-1:0] dir,
                                    logic rch, logic lst);
            t_thrust_cmd want;
            if (expected_cmds.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_CAP)
                    $display("%0t: expected no word, got pwm %0d dir %0d reached %0b last %0b",
                             $time, pwm, dir, rch, lst);
                return;
            end
            want = expected_cmds.pop_front();
            compare_field("pwm_level", want.pwm_level, pwm);
            compare_field("direction", PWM_W'(want.direction), PWM_W'(dir));
            compare_field("reached", PWM_W'(want.reached), PWM_W'(rch));
            compare_field("last", PWM_W'(want.last), PWM_W'(lst));
        endfunction

        function int pending();
            return expected_cmds.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels and the block itself.
    // ------------------------------------------------------------------------
    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    yppc_in_if  yaw_ch ();
    yppc_out_if cmd_ch ();

    thrust_scoreboard sb;

    // Idle behavior of the sample source and of the command sink; each phase
    // chooses whether its side idles at all.
    bit yaw_gaps_on;
    bit cmd_stalls_on;

    yaw_pid_pwm_controller_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (yaw_ch),
        .o_out      (cmd_ch)
    );

    initial begin : clock_gen
        i_clk = 1'b0;
        forever #(CLK_HALF_NS) i_clk = ~i_clk;
    end

    // Mostly no gap, often a short one, and now and then a long one that
    // can outlast the whole multiply-accumulate pass.
    function automatic int pick_gap(bit enabled);
        int pick;
        pick = $urandom_range(0, 99);
        if (!enabled || pick < 55) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [CFG_W-1:0] random_gain();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 20) return '0;
        if (pick < 30) return '1;
        if (pick < 65) return CFG_W'($urandom_range(1, 1023));
        return CFG_W'($urandom);
    endfunction

    function automatic t_heading_cfg random_config();
        t_heading_cfg     c;
        int               pick;
        int               band_val;
        logic [PWM_W-1:0] floor_pwm;
        pick = $urandom_range(0, 99);
        if (pick < 8)       c.target = YAW_MAX;
        else if (pick < 16) c.target = YAW_MIN;
        else                c.target = CFG_W'($urandom);
        c.kp         = random_gain();
        c.ki_dt      = random_gain();
        c.kd_over_dt = random_gain();
        pick = $urandom_range(0, 99);
        if (pick < 20)      floor_pwm = '0;
        else if (pick < 40) floor_pwm = FULL_PWM;
        else                floor_pwm = PWM_W'($urandom);
        c.min_word = {PWM_W'($urandom), floor_pwm};
        // Half the phases disable the reached test altogether; the rest use a
        // band that the sample picker keeps clear of.
        pick = $urandom_range(0, 99);
        if (pick < 50)      band_val = 0;
        else if (pick < 90) band_val = $urandom_range(1, 2000);
        else                band_val = $urandom_range(2001, 32767);
        c.band_word = {1'($urandom), BAND_W'(band_val)};
        return c;
    endfunction

    // A plausible heading trace: mostly small moves from the last sample,
    // with jumps, visits close to the target and the range ends mixed in.
    // Anything inside the reach band is pushed onto its edge, since reaching
    // the heading freezes the controller for the rest of the run.
    function automatic logic signed [ANGLE_W-1:0] next_yaw(logic signed [ANGLE_W-1:0] last_yaw);
        int pick, yaw, aim, band_val, aim_gap;
        pick     = $urandom_range(0, 99);
        aim      = sb.target;
        band_val = sb.band;
        if (pick < 45)
            yaw = int'(last_yaw) + int'($urandom_range(0, 1024)) - 512;
        else if (pick < 70)
            yaw = int'($signed(ANGLE_W'($urandom)));
        else if (pick < 85)
            yaw = aim + int'($urandom_range(0, 128)) - 64;
        else begin
            case ($urandom_range(0, 3))
                0:       yaw = YAW_MAX;
                1:       yaw = YAW_MIN;
                2:       yaw = 0;
                default: yaw = -1;
            endcase
        end
        if (yaw > int'(YAW_MAX)) yaw = YAW_MAX;
        if (yaw < int'(YAW_MIN)) yaw = YAW_MIN;
        aim_gap = (aim > yaw) ? aim - yaw : yaw - aim;
        if (band_val > 0 && aim_gap < band_val)
            yaw = (aim >= 0) ? aim - band_val : aim + band_val;
        return ANGLE_W'(yaw);
    endfunction

    // ------------------------------------------------------------------------
    // Driving tasks. Each one starts and ends at a falling edge; inputs only
    // change there, and handshakes are looked at on the rising edge.
    // ------------------------------------------------------------------------
    task automatic idle_yaw(int cycles);
        yaw_ch.valid <= 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    // Valid stays high straight into the next word when no gap is drawn.
    task automatic send_yaw(logic signed [ANGLE_W-1:0] yaw);
        int gap;
        gap = pick_gap(yaw_gaps_on);
        if (gap > 0) idle_yaw(gap);
        yaw_ch.valid      <= 1'b1;
        yaw_ch.yaw_sample <= yaw;
        do @(posedge i_clk); while (yaw_ch.ready !== 1'b1);
        sb.note_sample(yaw);
        @(negedge i_clk);
    endtask

    // Stops the sample stream and waits until every predicted word is back,
    // which leaves the block idle for register writes.
    task automatic drain_commands();
        idle_yaw(1);
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        sb.set_reg(idx, data);
        @(negedge i_clk);
    endtask

    task automatic load_config(t_heading_cfg c);
        write_reg(CFG_TARGET, c.target);
        write_reg(CFG_KP, c.kp);
        write_reg(CFG_KI_DT, c.ki_dt);
        write_reg(CFG_KD_DT, c.kd_over_dt);
        write_reg(CFG_MIN_PWM, c.min_word);
        write_reg(CFG_BAND, c.band_word);
        write_reg(($urandom_range(0, 1) != 0) ? CFG_SPARE_HI : CFG_SPARE_LO, CFG_W'($urandom));
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Command sink: ready changes on the falling edge, with stall runs drawn
    // like the source gaps, and every accepted word is checked at once.
    // ------------------------------------------------------------------------
    initial begin : command_sink
        int stall;
        stall        = 0;
        cmd_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                cmd_ch.ready <= 1'b0;
                stall--;
            end else begin
                cmd_ch.ready <= 1'b1;
                stall = pick_gap(cmd_stalls_on);
            end
            @(posedge i_clk);
            if (cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1)
                sb.check_command(cmd_ch.pwm_level, cmd_ch.direction,
                                 cmd_ch.reached, cmd_ch.last);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus. The reached flag can only be cleared by reset, which happens
    // once, so every phase keeps clear of the reach band until the last one.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        t_heading_cfg              cfg;
        logic signed [ANGLE_W-1:0] yaw;
        sb                = new();
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = '0;
        i_cfg_data        = '0;
        yaw_ch.valid      = 1'b0;
        yaw_ch.yaw_sample = '0;
        yaw_gaps_on       = 1'b1;
        cmd_stalls_on     = 1'b1;
        yaw               = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset defaults: target zero, unit proportional gain, band of 320.
        // The first word has no predecessor; it and the next word hit both clamp
        // limits, then errors sit exactly on the band edge where pwm is lifted
        // to the floor.
        send_yaw(YAW_MAX);
        send_yaw(YAW_MIN);
        send_yaw(16'sd320);
        send_yaw(-16'sd320);
        send_yaw(16'sd12345);
        send_yaw(-16'sd9000);
        drain_commands();

        // All gains zero, pwm floor zero: output is exactly zero, which maps
        // to clockwise. Junk in the upper bits of the floor and band words
        // must be dropped, leaving a band of zero that never counts reached.
        cfg = '{target: 16'h1234, kp: '0, ki_dt: '0, kd_over_dt: '0,
                min_word: 16'hFF00, band_word: 16'h8000};
        load_config(cfg);
        send_yaw(16'sh1234);
        send_yaw(-16'sd5);
        send_yaw(YAW_MAX);
        drain_commands();

        // Every gain at full scale with the target at the bottom of the
        // range and the floor at full pwm.
        cfg = '{target: YAW_MIN, kp: '1, ki_dt: '1, kd_over_dt: '1,
                min_word: 16'h00FF, band_word: '0};
        load_config(cfg);
        send_yaw(YAW_MIN);
        send_yaw(YAW_MAX);
        send_yaw(16'sd0);
        send_yaw(-16'sd1);
        drain_commands();

        // Derivative term alone, in both directions.
        cfg = '{target: '0, kp: '0, ki_dt: '0, kd_over_dt: 16'd4096,
                min_word: '0, band_word: '0};
        load_config(cfg);
        send_yaw(16'sd100);
        send_yaw(16'sd200);
        send_yaw(16'sd50);
        drain_commands();

        // Random phases, each with its own register set and idle pattern.
        repeat (RANDOM_PHASES) begin
            load_config(random_config());
            yaw_gaps_on   = ($urandom_range(0, 3) != 0);
            cmd_stalls_on = ($urandom_range(0, 3) != 0);
            repeat (PHASE_WORDS) begin
                yaw = next_yaw(yaw);
                send_yaw(yaw);
            end
            drain_commands();
        end

        // Push the integral upward with the largest possible error, back to
        // back, with the integral term alone driving the output.
        cfg = '{target: YAW_MAX, kp: '0, ki_dt: 16'd1, kd_over_dt: '0,
                min_word: '0, band_word: '0};
        load_config(cfg);
        yaw_gaps_on   = 1'b0;
        cmd_stalls_on = 1'b0;
        repeat (PUSH_WORDS) send_yaw(YAW_MIN);
        drain_commands();

        // Full proportional gain on an error of -32768 pulls against the
        // integral built up above.
        cfg = '{target: 16'hFFFF, kp: '1, ki_dt: 16'd1, kd_over_dt: '0,
                min_word: '0, band_word: '0};
        load_config(cfg);
        yaw_gaps_on   = 1'b1;
        cmd_stalls_on = 1'b1;
        send_yaw(YAW_MAX);
        repeat (10) begin
            yaw = next_yaw(yaw);
            send_yaw(yaw);
        end
        drain_commands();

        // Widest band: an error of 65535 and one of exactly 32767 stay
        // outside it, the next sample lands inside and the heading is
        // reached. From then on every sample yields one forward word, even
        // after the registers change.
        cfg = '{target: YAW_MAX, kp: 16'd256, ki_dt: '0, kd_over_dt: '0,
                min_word: 16'hA578, band_word: 16'hFFFF};
        load_config(cfg);
        send_yaw(YAW_MIN);
        send_yaw(16'sd0);
        send_yaw(16'sd1);
        repeat (20) send_yaw(ANGLE_W'($urandom));
        drain_commands();
        load_config(random_config());
        repeat (10) send_yaw(ANGLE_W'($urandom));
        drain_commands();

        // Give any stray word time to show up before judging the run.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("yaw_pid_pwm_controller_top_tb passed");
        else
            $display("yaw_pid_pwm_controller_top_tb failed");
        $finish;
    end

    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("yaw_pid_pwm_controller_top_tb failed");
        $finish;
    end

endmodule
